@@ rtl/pslt_pkg.sv @@
// Shared types and fixed constants of the packet sequence loss tracker.
// No dependencies; imported by packet_sequence_loss_tracker_top.
`default_nettype none

package pslt_pkg;

  // Header field widths
  localparam int LINK_ID_W = 3;
  localparam int ID_W      = 8;
  localparam int SEQ_W     = 8;
  localparam int PAIR_W    = 2 * ID_W;
  localparam int TOT_W     = 32;

  // Loss percentage, unsigned 7.8 fixed point
  localparam int PCT_W      = 15;
  localparam int PCT_FRAC_W = 8;
  localparam int PCT_SCALE  = 100;
  localparam int PCT_MAX    = PCT_SCALE << PCT_FRAC_W;
  // Quotient bits that the scaled numerator holds below its high part
  localparam int PCT_SPLIT  = PCT_W - PCT_FRAC_W;
  localparam int DIV_CNT_W  = $clog2(PCT_W);

  // Pair memory entry: seen flag and last sequence number
  typedef struct packed {
    logic             seen;
    logic [SEQ_W-1:0] last_seq;
  } pair_ent_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_CALC  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

@@ rtl/packet_sequence_loss_tracker_top.sv @@
// Packet sequence loss tracker: per-pair sequence memory, per-link counter
// memory and a bit-serial divider for the window loss percentage.
// Depends on pslt_pkg.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-------------------------------------
//   in_     | input     | in_valid/in_ready   | link, system, component, seq, known
//   out_    | output    | out_valid/out_ready | counted, lost, ratio, percent, totals
//
// After reset the pair memory is swept clear with in_ready low.
// One transaction at a time: accept, read-modify-write in ST_CALC, then load
// of the output register in ST_DONE. A packet that closes a window also passes
// through the one-bit-per-cycle divider in ST_DIV before the load.
// The output register holds a result while out_ready is low; the block then
// waits in its final state with in_ready low until the register frees.
`default_nettype none

module packet_sequence_loss_tracker_top
  import pslt_pkg::*;
#(
  parameter int LINK_COUNT     = 8,
  parameter int WINDOW_PACKETS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [LINK_ID_W-1:0] in_link_id,
  input  wire logic [ID_W-1:0]      in_system_id,
  input  wire logic [ID_W-1:0]      in_component_id,
  input  wire logic [SEQ_W-1:0]     in_sequence_number,
  input  wire logic                 in_source_known,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_counted,
  output logic [SEQ_W-1:0]          out_lost_now,
  output logic                      out_ratio_valid,
  output logic [PCT_W-1:0]          out_loss_percent,
  output logic [TOT_W-1:0]          out_total_received,
  output logic [TOT_W-1:0]          out_total_lost
);

  localparam int LIDX_W  = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;
  localparam int WR_W    = $clog2(WINDOW_PACKETS + 1);
  localparam int WL_W    = $clog2(255 * WINDOW_PACKETS + 1);
  localparam int MUL_W   = WL_W + PCT_SPLIT;
  localparam int DEN_W   = $clog2(256 * WINDOW_PACKETS + 1);
  localparam int PAIR_N  = 1 << PAIR_W;
  localparam int LEXT_W  = 9;

  typedef struct packed {
    logic [TOT_W-1:0] tot_rcv;
    logic [TOT_W-1:0] tot_lost;
    logic [WR_W-1:0]  win_rcv;
    logic [WL_W-1:0]  win_lost;
  } link_ent_t;

  // Memories
  pair_ent_t pair_mem [PAIR_N];
  link_ent_t link_mem [LINK_COUNT];

  // Control state
  state_t                 state_r, state_nxt;
  logic [PAIR_W-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [LINK_COUNT-1:0]  link_vld_r, link_vld_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Transaction payload
  logic [LIDX_W-1:0]      link_r;
  logic                   oor_r;
  logic                   known_r;
  logic [SEQ_W-1:0]       seq_r;
  logic                   lv_r;
  logic [PAIR_W-1:0]      pair_waddr_hold_r;
  pair_ent_t              pair_q_r;
  link_ent_t              link_q_r;
  logic [DEN_W-1:0]       rem_r, rem_nxt;
  logic [PCT_W-1:0]       q_r, q_nxt;
  logic [DEN_W-1:0]       den_r, den_nxt;
  logic                   res_counted_r, res_counted_nxt;
  logic [SEQ_W-1:0]       res_lost_r, res_lost_nxt;
  logic                   res_ratio_r, res_ratio_nxt;
  logic [TOT_W-1:0]       res_tr_r, res_tr_nxt;
  logic [TOT_W-1:0]       res_tl_r, res_tl_nxt;

  // Output register
  logic                   out_counted_r;
  logic [SEQ_W-1:0]       out_lost_r;
  logic                   out_ratio_r;
  logic [PCT_W-1:0]       out_pct_r;
  logic [TOT_W-1:0]       out_tr_r;
  logic [TOT_W-1:0]       out_tl_r;
  logic                   out_load;

  // Memory ports
  logic                   pm_we;
  logic [PAIR_W-1:0]      pm_waddr;
  pair_ent_t              pm_wdata;
  logic                   lm_we;
  link_ent_t              lm_wdata;

  // Datapath
  logic                   acc;
  logic [LEXT_W-1:0]      in_link_ext;
  logic [LIDX_W-1:0]      in_lidx;
  link_ent_t              link_cur;
  logic [SEQ_W-1:0]       expected;
  logic [SEQ_W-1:0]       lost;
  logic [TOT_W-1:0]       tr_new, tl_new;
  logic [WR_W-1:0]        wr_new;
  logic [WL_W-1:0]        wl_new;
  logic                   win_close;
  logic [MUL_W-1:0]       mul_full;
  logic [DEN_W+1:0]       diff;
  logic                   ge;

  assign in_ready    = (state_r == ST_IDLE);
  assign acc         = in_valid && in_ready;
  assign in_link_ext = LEXT_W'(in_link_id);
  assign in_lidx     = in_link_ext[LIDX_W-1:0];

  // Link entries never written read as zero
  assign link_cur = lv_r ? link_q_r : '0;

  // Forward gap from the expected sequence; a backward gap counts as zero
  assign expected  = pair_q_r.last_seq + 1'b1;
  assign lost      = (pair_q_r.seen && (seq_r > expected)) ? (seq_r - expected) : '0;
  assign tr_new    = link_cur.tot_rcv + 1'b1;
  assign tl_new    = link_cur.tot_lost + TOT_W'(lost);
  assign wr_new    = link_cur.win_rcv + 1'b1;
  assign wl_new    = link_cur.win_lost + WL_W'(lost);
  assign win_close = (wr_new >= WR_W'(WINDOW_PACKETS));
  assign mul_full  = MUL_W'(wl_new) * MUL_W'(PCT_SCALE);

  // One restoring division step
  assign diff = {1'b0, rem_r, q_r[PCT_W-1]} - {2'b00, den_r};
  assign ge   = ~diff[DEN_W+1];

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    link_vld_nxt    = link_vld_r;
    div_cnt_nxt     = div_cnt_r;
    rem_nxt         = rem_r;
    q_nxt           = q_r;
    den_nxt         = den_r;
    res_counted_nxt = res_counted_r;
    res_lost_nxt    = res_lost_r;
    res_ratio_nxt   = res_ratio_r;
    res_tr_nxt      = res_tr_r;
    res_tl_nxt      = res_tl_r;
    pm_we           = 1'b0;
    pm_waddr        = clr_cnt_r;
    pm_wdata        = '0;
    lm_we           = 1'b0;
    lm_wdata        = '0;
    out_load        = 1'b0;
    out_valid_nxt   = out_valid_r && !out_ready;

    unique case (state_r)
      // Sweep the pair memory clear
      ST_CLEAR: begin
        pm_we       = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          state_nxt = ST_CALC;
        end
      end
      // Update counters and write back both memories for a counted packet; launch the divider on a window close
      ST_CALC: begin
        res_counted_nxt = 1'b0;
        res_lost_nxt    = '0;
        res_ratio_nxt   = 1'b0;
        res_tr_nxt      = '0;
        res_tl_nxt      = '0;
        q_nxt           = '0;
        state_nxt       = ST_DONE;
        if (!oor_r && !known_r) begin
          res_tr_nxt = link_cur.tot_rcv;
          res_tl_nxt = link_cur.tot_lost;
        end else if (!oor_r) begin
          res_counted_nxt    = 1'b1;
          res_lost_nxt       = lost;
          res_ratio_nxt      = win_close;
          res_tr_nxt         = tr_new;
          res_tl_nxt         = tl_new;
          pm_we              = 1'b1;
          pm_waddr           = pair_waddr_hold_r;
          pm_wdata.seen      = 1'b1;
          pm_wdata.last_seq  = seq_r;
          lm_we              = 1'b1;
          lm_wdata.tot_rcv   = tr_new;
          lm_wdata.tot_lost  = tl_new;
          lm_wdata.win_rcv   = win_close ? '0 : wr_new;
          lm_wdata.win_lost  = win_close ? '0 : wl_new;
          link_vld_nxt[link_r] = 1'b1;
          if (win_close) begin
            rem_nxt     = DEN_W'(mul_full[MUL_W-1:PCT_SPLIT]);
            q_nxt       = {mul_full[PCT_SPLIT-1:0], {PCT_FRAC_W{1'b0}}};
            den_nxt     = DEN_W'(WINDOW_PACKETS) + DEN_W'(wl_new);
            div_cnt_nxt = '0;
            state_nxt   = ST_DIV;
          end
        end
      end
      // Shift one quotient bit per cycle
      ST_DIV: begin
        rem_nxt     = ge ? diff[DEN_W-1:0] : {rem_r[DEN_W-2:0], q_r[PCT_W-1]};
        q_nxt       = {q_r[PCT_W-2:0], ge};
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(PCT_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      // Load the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      link_vld_r  <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      link_vld_r  <= link_vld_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      link_r  <= in_lidx;
      oor_r   <= (in_link_ext >= LEXT_W'(LINK_COUNT));
      known_r <= in_source_known;
      seq_r   <= in_sequence_number;
      lv_r    <= link_vld_r[in_lidx];
    end
    rem_r         <= rem_nxt;
    q_r           <= q_nxt;
    den_r         <= den_nxt;
    res_counted_r <= res_counted_nxt;
    res_lost_r    <= res_lost_nxt;
    res_ratio_r   <= res_ratio_nxt;
    res_tr_r      <= res_tr_nxt;
    res_tl_r      <= res_tl_nxt;
    if (out_load) begin
      out_counted_r <= res_counted_r;
      out_lost_r    <= res_lost_r;
      out_ratio_r   <= res_ratio_r;
      out_pct_r     <= q_r;
      out_tr_r      <= res_tr_r;
      out_tl_r      <= res_tl_r;
    end
  end

  // Pair memory: write back the seen flag and sequence, read on accept
  always_ff @(posedge clk) begin
    if (pm_we) begin
      pair_mem[pm_waddr] <= pm_wdata;
    end
    if (acc) begin
      pair_q_r <= pair_mem[{in_system_id, in_component_id}];
    end
  end

  // Hold the pair address of the transaction under work
  always_ff @(posedge clk) begin
    if (acc) begin
      pair_waddr_hold_r <= {in_system_id, in_component_id};
    end
  end

  // Link memory: counters per link, read on accept
  always_ff @(posedge clk) begin
    if (lm_we) begin
      link_mem[link_r] <= lm_wdata;
    end
    if (acc) begin
      link_q_r <= link_mem[in_lidx];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_counted        = out_counted_r;
  assign out_lost_now       = out_lost_r;
  assign out_ratio_valid    = out_ratio_r;
  assign out_loss_percent   = out_pct_r;
  assign out_total_received = out_tr_r;
  assign out_total_lost     = out_tl_r;

  // Checks
  a_ratio_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ratio_valid |-> out_counted)
    else $error("window close reported for an uncounted packet");

  a_pct_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ratio_valid |-> out_loss_percent == '0)
    else $error("loss percentage set outside a window close");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_loss_percent <= PCT_W'(PCT_MAX))
    else $error("loss percentage above 100");

  a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_CALC)
    else $error("accepted transaction did not enter the update cycle");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> div_cnt_r < DIV_CNT_W'(PCT_W))
    else $error("divider ran past its last quotient bit");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking bench for packet_sequence_loss_tracker_top: predicts per-packet loss, totals
// and window loss percentages and checks every result transaction in order.
// Depends on pslt_pkg and the tracker RTL.
module testbench;
  import pslt_pkg::*;

  localparam int LINK_COUNT     = 8;
  localparam int WINDOW_PACKETS = 32;
  localparam int PAIR_COUNT     = 1 << PAIR_W;
  localparam int FLOWS          = 12;
  localparam int CYCLE_LIMIT    = 600000;

  typedef struct packed {
    logic [LINK_ID_W-1:0] link_id;
    logic [ID_W-1:0]      system_id;
    logic [ID_W-1:0]      component_id;
    logic [SEQ_W-1:0]     sequence_number;
    logic                 source_known;
  } header_t;

  typedef struct packed {
    logic             counted;
    logic [SEQ_W-1:0] lost_now;
    logic             ratio_valid;
    logic [PCT_W-1:0] loss_percent;
    logic [TOT_W-1:0] total_received;
    logic [TOT_W-1:0] total_lost;
  } loss_report_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [LINK_ID_W-1:0] in_link_id = '0;
  logic [ID_W-1:0]      in_system_id = '0;
  logic [ID_W-1:0]      in_component_id = '0;
  logic [SEQ_W-1:0]     in_sequence_number = '0;
  logic                 in_source_known = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_counted;
  logic [SEQ_W-1:0]     out_lost_now;
  logic                 out_ratio_valid;
  logic [PCT_W-1:0]     out_loss_percent;
  logic [TOT_W-1:0]     out_total_received;
  logic [TOT_W-1:0]     out_total_lost;

  packet_sequence_loss_tracker_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_link_id        (in_link_id),
    .in_system_id      (in_system_id),
    .in_component_id   (in_component_id),
    .in_sequence_number(in_sequence_number),
    .in_source_known   (in_source_known),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_counted       (out_counted),
    .out_lost_now      (out_lost_now),
    .out_ratio_valid   (out_ratio_valid),
    .out_loss_percent  (out_loss_percent),
    .out_total_received(out_total_received),
    .out_total_lost    (out_total_lost)
  );

  // Tracker state mirrored by the predictor
  bit               pair_seen [PAIR_COUNT];
  logic [SEQ_W-1:0] pair_last_seq [PAIR_COUNT];
  bit [TOT_W-1:0]   link_rx_total [LINK_COUNT];
  bit [TOT_W-1:0]   link_lost_total [LINK_COUNT];
  int unsigned      window_rx [LINK_COUNT];
  int unsigned      window_lost [LINK_COUNT];

  header_t      pending_packets [$];
  loss_report_t expected_reports [$];

  // Random flows: one (system, component) stream each
  logic [ID_W-1:0]      flow_sys [FLOWS];
  logic [ID_W-1:0]      flow_comp [FLOWS];
  logic [LINK_ID_W-1:0] flow_link [FLOWS];
  logic [SEQ_W-1:0]     flow_next [FLOWS];

  int error_count = 0;
  int packets_sent = 0;
  int results_checked = 0;
  int windows_seen = 0;
  int unknown_seen = 0;
  int peak_percent = 0;
  int cycle_count = 0;

  // Compute the result of one packet and advance the mirrored state
  function automatic loss_report_t track_packet(input header_t h);
    loss_report_t     r;
    int unsigned      pair;
    int unsigned      expected_seq;
    int unsigned      lost;
    longint unsigned  num;
    longint unsigned  den;
    r = '0;
    if (h.link_id >= LINK_COUNT) return r;
    if (!h.source_known) begin
      r.total_received = link_rx_total[h.link_id];
      r.total_lost     = link_lost_total[h.link_id];
      return r;
    end
    pair = {h.system_id, h.component_id};
    lost = 0;
    link_rx_total[h.link_id] += 1;
    window_rx[h.link_id] += 1;
    if (pair_seen[pair]) begin
      expected_seq = (pair_last_seq[pair] + 1) & 8'hFF;
      if (h.sequence_number > expected_seq) lost = h.sequence_number - expected_seq;
    end else begin
      pair_seen[pair] = 1'b1;
    end
    pair_last_seq[pair] = h.sequence_number;
    link_lost_total[h.link_id] += lost;
    window_lost[h.link_id] += lost;
    // Close the window once it holds a full set of received packets
    if (window_rx[h.link_id] >= WINDOW_PACKETS) begin
      num = longint'(window_lost[h.link_id]) * PCT_MAX;
      den = longint'(window_rx[h.link_id]) + longint'(window_lost[h.link_id]);
      r.ratio_valid  = 1'b1;
      r.loss_percent = PCT_W'(num / den);
      window_rx[h.link_id]   = 0;
      window_lost[h.link_id] = 0;
    end
    r.counted        = 1'b1;
    r.lost_now       = SEQ_W'(lost);
    r.total_received = link_rx_total[h.link_id];
    r.total_lost     = link_lost_total[h.link_id];
    return r;
  endfunction

  function automatic header_t make_header(input int link, input int sys, input int comp,
                                          input int seq, input bit known);
    header_t h;
    h.link_id         = LINK_ID_W'(link);
    h.system_id       = ID_W'(sys);
    h.component_id    = ID_W'(comp);
    h.sequence_number = SEQ_W'(seq);
    h.source_known    = known;
    return h;
  endfunction

  task automatic check_field(input string field, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  task automatic reseed_flow(input int f);
    flow_sys[f]  = ID_W'($urandom);
    flow_comp[f] = ID_W'($urandom);
    flow_link[f] = LINK_ID_W'($urandom);
    flow_next[f] = SEQ_W'($urandom);
  endtask

  // Queue mostly well-formed flow traffic, plus unknown sources and noise
  task automatic queue_random_packets(input int count);
    header_t h;
    int      f;
    int      pick;
    int      roll;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      f = $urandom_range(0, FLOWS - 1);
      if (pick < 2) reseed_flow(f);
      if (pick < 80) begin
        h.link_id = ($urandom_range(0, 9) == 0) ? LINK_ID_W'($urandom) : flow_link[f];
        h.system_id    = flow_sys[f];
        h.component_id = flow_comp[f];
        h.source_known = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 70) h.sequence_number = flow_next[f];
        else if (roll < 82) h.sequence_number = SEQ_W'(flow_next[f] + $urandom_range(1, 6));
        else if (roll < 88) h.sequence_number = SEQ_W'(flow_next[f] - $urandom_range(1, 20));
        else if (roll < 94) h.sequence_number = SEQ_W'($urandom);
        else h.sequence_number = SEQ_W'(flow_next[f] - 1);
        flow_next[f] = h.sequence_number + 1'b1;
      end else if (pick < 90) begin
        h = header_t'($urandom);
        h.source_known = 1'b0;
      end else begin
        h = header_t'($urandom);
      end
      pending_packets.push_back(h);
    end
  endtask

  // Repeat sequence 255 on one flow: every repeat after the first loses 255 sequence numbers
  task automatic queue_loss_storm(input int f, input int count);
    for (int n = 0; n < count; n++)
      pending_packets.push_back(make_header(flow_link[f], flow_sys[f], flow_comp[f], 255, 1'b1));
    flow_next[f] = '0;
  endtask

  task automatic wait_drained();
    while (pending_packets.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk);
  endtask

  // Clock and reset
  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Stimulus phases
  initial begin
    for (int f = 0; f < FLOWS; f++) reseed_flow(f);
    @(negedge clk);
    while (!rst_n) @(negedge clk);

    // Directed: first sighting, in order, gap, backward, wrap, unknown, extreme ids
    pending_packets.push_back(make_header(0, 0, 0, 10, 1'b1));
    pending_packets.push_back(make_header(0, 0, 0, 11, 1'b1));
    pending_packets.push_back(make_header(0, 0, 0, 20, 1'b1));
    pending_packets.push_back(make_header(0, 0, 0, 5, 1'b1));
    pending_packets.push_back(make_header(0, 0, 0, 255, 1'b1));
    pending_packets.push_back(make_header(0, 0, 0, 0, 1'b1));
    pending_packets.push_back(make_header(0, 0, 0, 100, 1'b0));
    pending_packets.push_back(make_header(7, 255, 255, 255, 1'b1));
    pending_packets.push_back(make_header(7, 255, 255, 0, 1'b1));
    pending_packets.push_back(make_header(7, 255, 255, 254, 1'b1));
    pending_packets.push_back(make_header(7, 0, 255, 0, 1'b0));
    pending_packets.push_back(make_header(3, 0, 0, 1, 1'b1));
    pending_packets.push_back(make_header(3, 0, 0, 1, 1'b1));
    pending_packets.push_back(make_header(5, 255, 0, 128, 1'b1));
    pending_packets.push_back(make_header(5, 255, 0, 127, 1'b1));
    wait_drained();

    queue_random_packets(450);
    queue_loss_storm(0, 40);
    queue_random_packets(450);
    wait_drained();

    queue_random_packets(400);
    queue_loss_storm(1, 36);
    queue_random_packets(400);
    wait_drained();

    repeat (40) @(negedge clk);
    $display("Covered %0d packets (%0d from unknown sources), %0d results checked",
             packets_sent, unknown_seen, results_checked);
    $display("Saw %0d window reports, peak window loss %0d/256 percent",
             windows_seen, peak_percent);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Driver: bursts of transactions separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  header_t drive_hdr;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      // Predict on acceptance
      if (in_valid && in_ready) begin
        expected_reports.push_back(track_packet(drive_hdr));
        packets_sent++;
        if (!drive_hdr.source_known) unknown_seen++;
      end
      // Offer the next transaction once the current one is gone
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_packets.size() > 0) begin
          drive_hdr = pending_packets.pop_front();
          in_link_id         <= drive_hdr.link_id;
          in_system_id       <= drive_hdr.system_id;
          in_component_id    <= drive_hdr.component_id;
          in_sequence_number <= drive_hdr.sequence_number;
          in_source_known    <= drive_hdr.source_known;
          in_valid           <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: randomly chosen stall pattern that changes over time, plus one long hold-off
  int  ready_mode = 0;
  int  mode_left = 0;
  int  long_hold = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold = long_hold - 1;
      out_ready <= 1'b0;
    end else if (!long_hold_done && results_checked >= 400) begin
      long_hold = 600;
      long_hold_done = 1'b1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= (cycle_count[2:0] != 3'd0);
      endcase
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_monitor
    loss_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        error_count++;
        $display("%0t: result transaction with no packet pending, lost_now %0d",
                 $time, out_lost_now);
      end else begin
        want = expected_reports.pop_front();
        check_field("counted", want.counted, out_counted);
        check_field("lost_now", want.lost_now, out_lost_now);
        check_field("ratio_valid", want.ratio_valid, out_ratio_valid);
        check_field("loss_percent", want.loss_percent, out_loss_percent);
        check_field("total_received", want.total_received, out_total_received);
        check_field("total_lost", want.total_lost, out_total_lost);
        results_checked++;
        if (want.ratio_valid) begin
          windows_seen++;
          if (int'(want.loss_percent) > peak_percent) peak_percent = int'(want.loss_percent);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_reports.size());
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
